FILE: hdl/qmac_pkg.sv
// qmac_pkg: shared types, quantizer limits and saturation helper for the
// quantized int8 multiply-accumulate core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qmac_pkg;

  // clamp limits on the raw q8.8 inputs
  localparam logic signed [15:0] WGT_LO  = -16'sd512;   // -2.0
  localparam logic signed [15:0] WGT_HI  = 16'sd508;    // 1.984375
  localparam logic signed [15:0] ACT_LO  = -16'sd4096;  // -16.0
  localparam logic signed [15:0] ACT_HI  = 16'sd4064;   // 15.875
  localparam logic signed [15:0] BIAS_LO = -16'sd2048;  // -8.0
  localparam logic signed [15:0] BIAS_HI = 16'sd2032;   // 7.9375

  // half an lsb of the q4.3 activation code, in q8.8
  localparam logic signed [15:0] ACT_HALF = 16'sd16;

  localparam int unsigned ACC_W  = 32;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned PROD_W = 2 * CODE_W;

  typedef logic signed [CODE_W-1:0] code_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  // control that travels with one item between stages
  typedef struct packed {
    logic valid;
    logic last;
  } qmac_ctl_t;

  // clip a sum that is one bit wider than the accumulator
  function automatic acc_t sat_acc(input logic signed [ACC_W:0] s);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/qmac_quant.sv
// qmac_quant: clamps the q8.8 weight, activation and bias, offsets the activation
// by half an lsb, and truncates toward zero to int8 codes. Depends on qmac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qmac_quant import qmac_pkg::*; (
  input  wire logic signed [15:0] weight,
  input  wire logic signed [15:0] activation,
  input  wire logic signed [15:0] row_bias,
  output code_t                   w_code,
  output code_t                   a_code,
  output code_t                   b_code
);

  logic signed [15:0] w_clip;
  logic signed [15:0] a_clip;
  logic signed [15:0] b_clip;
  logic signed [15:0] w_adj;
  logic signed [15:0] a_off;
  logic signed [15:0] a_adj;
  logic signed [15:0] b_adj;

  always_comb begin
    w_clip = (weight < WGT_LO) ? WGT_LO : ((weight > WGT_HI) ? WGT_HI : weight);
    a_clip = (activation < ACT_LO) ? ACT_LO :
             ((activation > ACT_HI) ? ACT_HI : activation);
    b_clip = (row_bias < BIAS_LO) ? BIAS_LO :
             ((row_bias > BIAS_HI) ? BIAS_HI : row_bias);

    // negative values get divisor-1 added so the floor shift truncates toward zero
    w_adj = w_clip + (w_clip[15] ? 16'sd3 : 16'sd0);
    a_off = a_clip + ACT_HALF;
    a_adj = a_off + (a_off[15] ? 16'sd31 : 16'sd0);
    b_adj = b_clip + (b_clip[15] ? 16'sd15 : 16'sd0);
  end

  assign w_code = w_adj[9:2];
  assign a_code = a_adj[12:5];
  assign b_code = b_adj[11:4];

endmodule

`default_nettype wire

FILE: hdl/qmac_accum.sv
// qmac_accum: saturating accumulator, end-of-row bias add and result
// register with the out_ handshake. Depends on qmac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qmac_accum import qmac_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire qmac_ctl_t  prod_ctl,
  input  wire prod_t      prod,
  input  wire code_t      bias_code,
  output logic            prod_take,
  output logic            out_valid,
  input  wire logic       out_stall,
  output acc_t            out_dot_result
);

  acc_t  acc_r,   acc_nxt;
  acc_t  sum_r,   sum_nxt;
  code_t bias_r,  bias_nxt;
  logic  sv_r,    sv_nxt;
  acc_t  out_r,   out_nxt;
  logic  ov_r,    ov_nxt;

  logic  out_rdy;
  logic  sum_rdy;
  acc_t  acc_add;

  logic signed [ACC_W:0] prod_sum;
  logic signed [ACC_W:0] bias_sum;

  assign out_rdy   = !ov_r || !out_stall;
  assign sum_rdy   = !sv_r || out_rdy;
  // a non-last product never waits; a last one needs the sum register
  assign prod_take = prod_ctl.valid && (!prod_ctl.last || sum_rdy);

  always_comb begin
    prod_sum = {acc_r[ACC_W-1], acc_r}
             + {{(ACC_W+1-PROD_W-7){prod[PROD_W-1]}}, prod, 7'b0};
    acc_add  = sat_acc(prod_sum);
    bias_sum = {sum_r[ACC_W-1], sum_r}
             + {{(ACC_W+1-CODE_W-12){bias_r[CODE_W-1]}}, bias_r, 12'b0};

    acc_nxt  = acc_r;
    sum_nxt  = sum_r;
    bias_nxt = bias_r;
    sv_nxt   = sv_r;
    out_nxt  = out_r;
    ov_nxt   = ov_r;

    if (out_rdy) begin
      ov_nxt = sv_r;
      if (sv_r) begin
        out_nxt = sat_acc(bias_sum);
      end
      sv_nxt = 1'b0;
    end

    if (prod_take) begin
      if (prod_ctl.last) begin
        acc_nxt  = '0;
        sum_nxt  = acc_add;
        bias_nxt = bias_code;
        sv_nxt   = 1'b1;
      end else begin
        acc_nxt = acc_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      sv_r  <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      sv_r  <= sv_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    bias_r <= bias_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid      = ov_r;
  assign out_dot_result = out_r;

endmodule

`default_nettype wire

FILE: hdl/quantized_int8_mac_with_bias_core.sv
// quantized_int8_mac_with_bias_core: top level; input and product stages,
// wired to qmac_quant and qmac_accum. Depends on qmac_pkg.
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_valid / in_stall  | in_weight, in_activation, in_row_bias, in_last
//  out_    | out | out_valid / out_stall| out_dot_result
//
// one item per cycle when out_stall is low; out_valid rises from the result register
// after the in_ transfer of a last item has passed the code, product, sum and bias
// registers in that order (the code register loaded at the transfer itself).
// rst_n is synchronous: the accumulator clears and all stages empty.
// a held result does not block accumulation of following non-last items;
// input stalls only once the stages behind the result register are full.
`timescale 1ns / 1ps
`default_nettype none

module quantized_int8_mac_with_bias_core import qmac_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] in_weight,
  input  wire logic signed [15:0] in_activation,
  input  wire logic signed [15:0] in_row_bias,
  input  wire logic               in_last,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_dot_result
);

  code_t w_code, a_code, b_code;

  code_t     wq_r,  wq_nxt;
  code_t     aq_r,  aq_nxt;
  code_t     bq_r,  bq_nxt;
  qmac_ctl_t c1_r,  c1_nxt;

  prod_t     prod_r, prod_nxt;
  code_t     bp_r,   bp_nxt;
  qmac_ctl_t c2_r,   c2_nxt;

  logic prod_take;
  logic s2_rdy;
  logic s1_rdy;
  logic in_xfer;

  qmac_quant u_quant (
    .weight     (in_weight),
    .activation (in_activation),
    .row_bias   (in_row_bias),
    .w_code     (w_code),
    .a_code     (a_code),
    .b_code     (b_code)
  );

  assign s2_rdy   = !c2_r.valid || prod_take;
  assign s1_rdy   = !c1_r.valid || s2_rdy;
  assign in_stall = !s1_rdy;
  assign in_xfer  = in_valid && s1_rdy;

  always_comb begin
    wq_nxt   = wq_r;
    aq_nxt   = aq_r;
    bq_nxt   = bq_r;
    c1_nxt   = c1_r;
    prod_nxt = prod_r;
    bp_nxt   = bp_r;
    c2_nxt   = c2_r;

    if (s2_rdy) begin
      c2_nxt = c1_r;
      if (c1_r.valid) begin
        prod_nxt = wq_r * aq_r;
        bp_nxt   = bq_r;
      end
    end

    if (s1_rdy) begin
      c1_nxt.valid = in_valid;
      c1_nxt.last  = in_last;
      if (in_xfer) begin
        wq_nxt = w_code;
        aq_nxt = a_code;
        bq_nxt = b_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
    end else begin
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wq_r   <= wq_nxt;
    aq_r   <= aq_nxt;
    bq_r   <= bq_nxt;
    prod_r <= prod_nxt;
    bp_r   <= bp_nxt;
  end

  qmac_accum u_accum (
    .clk            (clk),
    .rst_n          (rst_n),
    .prod_ctl       (c2_r),
    .prod           (prod_r),
    .bias_code      (bp_r),
    .prod_take      (prod_take),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dot_result (out_dot_result)
  );

endmodule

`default_nettype wire

FILE: hdl/qmac_checker.sv
// qmac_checker: port-level assertions for the core, attached by bind.
// Depends only on the ports of quantized_int8_mac_with_bias_core.
`timescale 1ns / 1ps
`default_nettype none

module qmac_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] out_dot_result
);

  // stages are empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // with no result held every stage can move, so input never stalls
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output register empty");

  a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_dot_result))
    else $error("stalled result changed");

endmodule

bind quantized_int8_mac_with_bias_core qmac_checker u_qmac_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_dot_result (out_dot_result)
);

`default_nettype wire

FILE: dv/tb_quantized_int8_mac_with_bias_core.sv
// tb_quantized_int8_mac_with_bias_core: self-checking bench for the quantized int8
// multiply-accumulate core; predicts each dot product and compares it per transfer.
// Depends on quantized_int8_mac_with_bias_core, and through it on qmac_pkg.
`timescale 1ns / 1ps

module tb_quantized_int8_mac_with_bias_core;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;
  localparam int ITEM_BUDGET = 1950;
  localparam longint ACC_MAX = 64'sd2147483647;
  localparam longint ACC_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [15:0] weight;
    logic signed [15:0] activation;
    logic signed [15:0] row_bias;
    logic               last;
  } mac_item_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_weight;
  logic signed [15:0] in_activation;
  logic signed [15:0] in_row_bias;
  logic               in_last;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_dot_result;

  mac_item_t          item_q[$];
  logic signed [31:0] dot_expect_q[$];
  logic signed [31:0] dot_acc;
  int                 err_count;
  int                 in_count;
  logic               in_took;
  logic               out_took;
  int                 in_wait;
  int                 out_wait;
  logic               in_burst;
  logic               out_burst;
  logic               rx_hold;

  quantized_int8_mac_with_bias_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_weight      (in_weight),
    .in_activation  (in_activation),
    .in_row_bias    (in_row_bias),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dot_result (out_dot_result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------- prediction ----------------

  function automatic logic signed [31:0] clip32(input longint s);
    if (s > ACC_MAX) return ACC_MAX[31:0];
    if (s < ACC_MIN) return ACC_MIN[31:0];
    return s[31:0];
  endfunction

  // clamp the raw q8.8 value, add the offset, then scale to int8 truncating toward zero
  function automatic int quantize(input logic signed [15:0] raw, input int lo, input int hi,
                                  input int offset, input int step);
    int c;
    c = raw;
    if (c < lo) c = lo;
    if (c > hi) c = hi;
    return (c + offset) / step;
  endfunction

  task automatic mac_accumulate(input mac_item_t it);
    int qw;
    int qa;
    int qb;
    qw = quantize(it.weight, -512, 508, 0, 4);
    qa = quantize(it.activation, -4096, 4064, 16, 32);
    dot_acc = clip32(longint'(dot_acc) + longint'(qw * qa * 128));
    if (it.last) begin
      qb = quantize(it.row_bias, -2048, 2032, 0, 16);
      dot_expect_q.push_back(clip32(longint'(dot_acc) + longint'(qb) * 4096));
      dot_acc = '0;
    end
  endtask

  // ---------------- stimulus ----------------

  task automatic add_item(input int w, input int a, input int b, input bit l);
    mac_item_t it;
    it.weight     = w[15:0];
    it.activation = a[15:0];
    it.row_bias   = b[15:0];
    it.last       = l;
    item_q.push_back(it);
  endtask

  // mostly in range, some raw 16-bit noise, some clamp edges, raw extremes or zero
  function automatic int pick_value(input int lo, input int hi);
    int edges[7];
    int sel;
    edges = '{lo, hi, lo - 1, hi + 1, -32768, 32767, 0};
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, hi - lo) + lo;
    if (sel < 8) return int'($urandom_range(0, 65535)) - 32768;
    return edges[$urandom_range(0, 6)];
  endfunction

  task automatic add_random_item(input bit l);
    add_item(pick_value(-512, 508), pick_value(-4096, 4064), pick_value(-2048, 2032), l);
  endtask

  // one long dot product of full-scale codes that drives the accumulator into saturation
  task automatic add_saturating_run();
    bit neg_sum;
    bit w_pos;
    int w;
    int a;
    neg_sum = $urandom_range(0, 1);
    for (int i = 0; i < 1050; i++) begin
      w_pos = $urandom_range(0, 1);
      w = w_pos ? int'($urandom_range(508, 32767)) : -int'($urandom_range(512, 32768));
      a = (w_pos ^ neg_sum) ? int'($urandom_range(4048, 32767))
                            : -int'($urandom_range(4080, 32768));
      add_item(w, a, pick_value(-2048, 2032), 1'b0);
    end
    for (int i = 0; i < 10; i++) add_random_item(1'b0);
    add_random_item(1'b1);
  endtask

  initial begin
    int len;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_weight     = '0;
    in_activation = '0;
    in_row_bias   = '0;
    in_last       = 1'b0;
    out_stall     = 1'b0;
    dot_acc       = '0;
    err_count     = 0;
    in_count      = 0;
    in_took       = 1'b0;
    out_took      = 1'b0;
    in_wait       = 0;
    out_wait      = 0;
    in_burst      = 1'b0;
    out_burst     = 1'b0;
    rx_hold       = 1'b0;

    // zero, raw extremes, clamp edges and one past them
    add_item(0, 0, 0, 1'b1);
    add_item(32767, 32767, 32767, 1'b1);
    add_item(-32768, -32768, -32768, 1'b1);
    add_item(508, 4064, 2032, 1'b0);
    add_item(509, 4065, 2033, 1'b1);
    add_item(-512, -4096, -2048, 1'b0);
    add_item(-513, -4097, -2049, 1'b1);
    // truncation toward zero and the +0.5 step of the activation
    add_item(-3, -17, -15, 1'b1);
    add_item(-4, -48, -16, 1'b1);
    add_item(3, 15, 15, 1'b0);
    add_item(4, 16, 16, 1'b1);
    add_item(-5, -49, -17, 1'b1);
    add_item(-1, 4047, -1, 1'b0);
    add_item(1, -4079, 1, 1'b1);
    // bias is ignored on non-last items
    add_item(256, 256, 32767, 0);
    add_item(256, 256, -32768, 0);
    add_item(-256, 256, 0, 1'b1);
    // alternating bit patterns, then one item mixing the raw extremes and 1
    add_item(16'haaaa, 16'h5555, 16'haaaa, 1'b0);
    add_item(16'h5555, 16'haaaa, 16'h5555, 1'b1);
    add_item(16'h8000, 16'h7fff, 16'h0001, 1'b1);

    add_saturating_run();
    while (item_q.size() < ITEM_BUDGET) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 1; i < len; i++) add_random_item(1'b0);
      add_random_item(1'b1);
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (item_q.size() != 0 || in_valid) @(negedge clk);
    while (dot_expect_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ---------------- driver ----------------

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (item_q.size() != 0) begin
        mac_item_t it;
        it = item_q.pop_front();
        in_weight     <= it.weight;
        in_activation <= it.activation;
        in_row_bias   <= it.row_bias;
        in_last       <= it.last;
        in_valid      <= 1'b1;
        // keep offering back to back in a burst or while the receiver holds off
        in_wait = (in_burst || rx_hold) ? 0 : $urandom_range(0, 11);
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver ----------------

  always @(negedge clk) begin
    if (out_took) begin
      out_wait = out_burst ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
    end
    if (rx_hold) begin
      out_stall <= 1'b1;
    end else if (out_wait > 0) begin
      out_stall <= 1'b1;
      if (out_valid) out_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // long hold-off so the stages fill and the input stalls
  initial begin
    for (int k = 0; k < 2; k++) begin
      while (in_count < (k == 0 ? 400 : 1500)) @(posedge clk);
      rx_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      rx_hold = 1'b0;
    end
  end

  // ---------------- monitor and checker ----------------

  always @(posedge clk) begin
    logic signed [31:0] want;
    in_took  = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;
    if (in_took) begin
      in_count++;
      mac_accumulate({in_weight, in_activation, in_row_bias, in_last});
    end
    if (out_took) begin
      if (dot_expect_q.size() == 0) begin
        $error("dot_result: no transfer expected, got %0d", out_dot_result);
        err_count++;
      end else begin
        want = dot_expect_q.pop_front();
        if (out_dot_result !== want) begin
          $error("dot_result: expected %0d, actual %0d", want, out_dot_result);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer on either channel
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: quantized_int8_mac_with_bias_core.f
hdl/qmac_pkg.sv
hdl/qmac_quant.sv
hdl/qmac_accum.sv
hdl/quantized_int8_mac_with_bias_core.sv
hdl/qmac_checker.sv
dv/tb_quantized_int8_mac_with_bias_core.sv
